>>> design/utf8_stream_decoder_defines.svh
// assertion macros shared by the utf8 stream decoder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UTF8_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// next-cycle implication, disabled while reset is low
`define UTF8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

>>> design/utf8_dec_pkg.sv
// types, status codes and lead-byte helpers for the utf8 stream decoder
// no dependencies; imported by the decoder and its checker
`timescale 1ns / 1ps

package utf8_dec_pkg;

  // default width of the offset and character counters
  localparam int unsigned CountBitsDefault = 32;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_BAD_LEAD = 3'd1,
    STATUS_TERM     = 3'd2,
    STATUS_ZERO_CP  = 3'd3,
    STATUS_TRUNC    = 3'd4
  } status_e;

  // one input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_string;
    logic       end_of_string;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [30:0] codepoint;
    logic [2:0]  seq_length;
    logic [31:0] start_offset;
    logic [31:0] char_index;
    status_e     status;
  } out_beat_t;

  // sequence length announced by a lead byte, zero when it is no lead byte
  function automatic logic [2:0] lead_size(input logic [7:0] b);
    logic [2:0] size;
    size = 3'd0;
    if (b[7] == 1'b0)            size = 3'd1;
    else if (b[7:5] == 3'b110)   size = 3'd2;
    else if (b[7:4] == 4'b1110)  size = 3'd3;
    else if (b[7:3] == 5'b11110) size = 3'd4;
    else if (b[7:2] == 6'b111110) size = 3'd5;
    else if (b[7:1] == 7'b1111110) size = 3'd6;
    return size;
  endfunction

  // payload bits a lead byte carries for a given length
  function automatic logic [6:0] lead_payload(input logic [7:0] b, input logic [2:0] size);
    logic [6:0] mask;
    case (size)
      3'd1:    mask = 7'h7F;
      3'd2:    mask = 7'h1F;
      3'd3:    mask = 7'h0F;
      3'd4:    mask = 7'h07;
      3'd5:    mask = 7'h03;
      3'd6:    mask = 7'h01;
      default: mask = 7'h00;
    endcase
    return b[6:0] & mask;
  endfunction

endpackage

>>> design/utf8_stream_decoder.sv
// utf8 stream decoder top level: input register, decode logic, result register
// depends on utf8_dec_pkg
`timescale 1ns / 1ps

// Decodes a byte stream in the original UTF-8 form with sequences of one to
// six bytes. One byte is accepted per cycle, back to back, as long as the
// result side keeps up; a stalled result beat holds the input register and,
// through it, the input. A result becomes valid on the output once its byte
// has passed the input register and then the result register, and only for
// bytes that finish a character or hit an error.
// The decode state (owed bytes, partial value, offsets, character count) is
// updated in the cycle a byte leaves the input register, so the next byte
// always sees it. Errors (zero byte, bad lead, zero code point, cut-off
// sequence) and the last byte of a string stop the block until a beat with
// first_of_string set. Offsets and the count are COUNT_BITS wide, wrap, and
// are shown as 32 bits, zero-extended, or cut when COUNT_BITS is wider.
module utf8_stream_decoder
  import utf8_dec_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  // pipeline registers
  logic      s1_valid_q, s1_valid_d;
  in_beat_t  s1_beat_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q, out_beat_d;

  // decode state
  logic [2:0]            owed_q, owed_d;
  logic [30:0]           partial_q, partial_d;
  logic [2:0]            cur_len_q, cur_len_d;
  logic [COUNT_BITS-1:0] seq_start_q, seq_start_d;
  logic [COUNT_BITS-1:0] offset_q, offset_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  stopped_q, stopped_d;

  logic out_free;
  logic fire;
  logic emit;

  // handshake
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // decode one byte against the current state
  always_comb begin
    logic [7:0]  b;
    logic [2:0]  size;
    logic [2:0]  owed_dec;
    logic [30:0] shifted;
    owed_d      = owed_q;
    partial_d   = partial_q;
    cur_len_d   = cur_len_q;
    seq_start_d = seq_start_q;
    offset_d    = offset_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    emit        = 1'b0;
    out_beat_d  = out_beat_q;
    b           = s1_beat_q.in_byte;
    size        = lead_size(b);
    owed_dec    = 3'd0;
    shifted     = 31'd0;

    if (fire) begin
      // string start clears everything before the byte
      if (s1_beat_q.first_of_string) begin
        owed_d      = 3'd0;
        partial_d   = 31'd0;
        cur_len_d   = 3'd0;
        seq_start_d = '0;
        offset_d    = '0;
        count_d     = '0;
        stopped_d   = 1'b0;
      end

      if (!stopped_d) begin
        if (s1_beat_q.end_of_string) begin
          stopped_d = 1'b1;
        end
        out_beat_d.codepoint  = 31'd0;
        out_beat_d.seq_length = 3'd0;
        out_beat_d.status     = STATUS_OK;

        if (owed_d == 3'd0) begin
          // lead byte
          seq_start_d = offset_d;
          offset_d    = offset_d + COUNT_BITS'(1);
          emit        = 1'b1;
          if (b == 8'd0) begin
            stopped_d         = 1'b1;
            out_beat_d.status = STATUS_TERM;
          end else if (size == 3'd0) begin
            stopped_d         = 1'b1;
            out_beat_d.status = STATUS_BAD_LEAD;
          end else if (size == 3'd1) begin
            count_d               = count_d + COUNT_BITS'(1);
            out_beat_d.codepoint  = 31'(b);
            out_beat_d.seq_length = 3'd1;
          end else begin
            partial_d = 31'(lead_payload(b, size));
            cur_len_d = size;
            owed_d    = size - 3'd1;
            emit      = s1_beat_q.end_of_string;
            if (s1_beat_q.end_of_string) begin
              owed_d                = 3'd0;
              out_beat_d.seq_length = size;
              out_beat_d.status     = STATUS_TRUNC;
            end
          end
        end else begin
          // continuation byte, top bits not checked
          offset_d  = offset_d + COUNT_BITS'(1);
          shifted   = {partial_d[24:0], b[5:0]};
          owed_dec  = owed_d - 3'd1;
          partial_d = shifted;
          owed_d    = owed_dec;
          out_beat_d.seq_length = cur_len_d;
          if (owed_dec == 3'd0) begin
            emit      = 1'b1;
            partial_d = 31'd0;
            if (shifted == 31'd0) begin
              stopped_d         = 1'b1;
              out_beat_d.status = STATUS_ZERO_CP;
            end else begin
              count_d              = count_d + COUNT_BITS'(1);
              out_beat_d.codepoint = shifted;
            end
          end else if (s1_beat_q.end_of_string) begin
            emit              = 1'b1;
            owed_d            = 3'd0;
            partial_d         = 31'd0;
            out_beat_d.status = STATUS_TRUNC;
          end
        end
        out_beat_d.start_offset = 32'(seq_start_d);
        out_beat_d.char_index   = 32'(count_d);
      end
    end
  end

  // input and result valid flags
  always_comb begin
    s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
    out_valid_d = out_free ? (fire && emit) : out_valid_q;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      owed_q      <= 3'd0;
      partial_q   <= 31'd0;
      cur_len_q   <= 3'd0;
      seq_start_q <= '0;
      offset_q    <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      owed_q      <= owed_d;
      partial_q   <= partial_d;
      cur_len_q   <= cur_len_d;
      seq_start_q <= seq_start_d;
      offset_q    <= offset_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_beat_q <= in_beat_i;
    end
    if (fire && emit) begin
      out_beat_q <= out_beat_d;
    end
  end

endmodule

>>> design/utf8_dec_checker.sv
// port-level checks for the utf8 stream decoder, bound to its top level
// depends on utf8_dec_pkg and utf8_stream_decoder_defines.svh
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module utf8_dec_checker
  import utf8_dec_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  logic is_ok;
  logic len_legal;
  logic no_len_err;
  logic in_stall;
  logic out_stall;
  logic ok_beat;
  logic err_beat;
  logic err_len_ok;

  assign is_ok      = out_beat_o.status == STATUS_OK;
  assign len_legal  = (out_beat_o.seq_length != 3'd0) && (out_beat_o.seq_length != 3'd7);
  assign no_len_err = (out_beat_o.status == STATUS_TERM) ||
                      (out_beat_o.status == STATUS_BAD_LEAD);
  assign in_stall   = in_valid_i && !in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign ok_beat    = out_valid_o && is_ok;
  assign err_beat   = out_valid_o && !is_ok;
  assign err_len_ok = no_len_err ? (out_beat_o.seq_length == 3'd0)
                                 : (out_beat_o.seq_length >= 3'd2);

  // a stalled input beat holds
  `UTF8_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_beat_i))

  // a stalled result beat holds
  `UTF8_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_beat_o))

  // good characters carry a nonzero code point and a real length
  `UTF8_ASSERT_NOW(a_ok_shape, clk_i, rst_ni, ok_beat, (out_beat_o.codepoint != 31'd0) && len_legal)

  // error beats carry no code point
  `UTF8_ASSERT_NOW(a_err_no_cp, clk_i, rst_ni, err_beat, out_beat_o.codepoint == 31'd0)

  // terminator and bad lead report length zero, truncation and zero code point at least two
  `UTF8_ASSERT_NOW(a_err_len, clk_i, rst_ni, err_beat, err_len_ok)

endmodule

bind utf8_stream_decoder utf8_dec_checker u_utf8_dec_checker (.*);
